// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

// File: hw/rtl/cswc_pkg.sv
package cswc_pkg;

    // Default limit on the smoothing half width.
    localparam int MAX_HALF_WIDTH_DEFAULT = 512;

    // Field and register widths.
    localparam int COUNT_W      = 8;
    localparam int HALF_WIDTH_W = 10;
    localparam int STEP_W       = 16;
    localparam int CHROM_W      = 32;
    localparam int POS_W        = 32;
    localparam int COV_W        = 18;

    // Stream and configuration port widths.
    localparam int S_TDATA_W   = ((COUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((POS_W + COV_W + 7) / 8) * 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HALF_WIDTH = 2'd0,
        REG_STEP       = 2'd1,
        REG_CHROM_SIZE = 2'd2
    } cfg_reg_t;

    // Contents of the stage between the input and the result register.
    typedef struct packed {
        logic               hit;
        logic [POS_W-1:0]   pos;
        logic [COUNT_W-1:0] count;
        logic               old_ok;
    } stage_t;

endpackage

// File: hw/rtl/cswc_ram.sv
module cswc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write and one registered read per cycle. A read of the address being
    // written returns the old contents.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/cut_site_window_coverage.sv
// Sliding-window coverage of cut sites with decimated output.
// The s_ channel carries one cut count per base, bases in order from 1.
// The m_ channel carries (position, coverage) for base p = bases seen - h,
// where h is the half width, emitted when 1 <= p < chrom_size and p falls
// on the step grid. Many inputs produce no transfer on the m_ channel.
// Configuration goes through cfg_we / cfg_index / cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// Writing the half width restarts the stream at base 1. Throughput: one input
// transfer per cycle while the result register is not stalled, set by the
// single-port-per-side delay-line RAM (one read and one write of the same slot
// per base). A result reaches the m_ channel through the middle stage, beside
// the registered RAM read, and then the sum and result register. Reset clears the
// running sum, counters and pointer; the delay line needs no clearing pass,
// since slots not yet written since the last restart read as zero through a
// wrap flag. Registers reset to half width 0, step 1, chrom_size 1.
// When the receiver stalls, the result register holds; one more input is
// taken into the middle stage, after which s_tready drops until m_tready.
`include "assert_macros.svh"

module cut_site_window_coverage #(
    parameter int MAX_HALF_WIDTH = cswc_pkg::MAX_HALF_WIDTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream. s_tdata: [7:0] cut_count.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cswc_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result stream. m_tdata: [31:0] position, [49:32] coverage, rest zero.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cswc_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [cswc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cswc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import cswc_pkg::*;

    localparam int DEPTH = 2 * MAX_HALF_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = HALF_WIDTH_W + 1;
    localparam int CW    = (AW + 1 > DW) ? AW + 1 : DW;

    // Configuration registers.
    logic [HALF_WIDTH_W-1:0] half_width_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [CHROM_W-1:0]      chrom_size_reg;

    // Stream state.
    logic [AW-1:0]     ptr_reg;
    logic              wrapped_reg;
    logic [POS_W-1:0]  index_reg;
    logic [STEP_W-1:0] phase_reg;
    logic [COV_W-1:0]  sum_reg;

    // Middle stage and result register.
    logic              p1_valid_reg;
    stage_t            p1_reg;
    stage_t            p1_next;
    logic              m_tvalid_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic [COV_W-1:0]  m_cov_reg;

    logic                    s_accept;
    logic                    advance;
    logic [HALF_WIDTH_W-1:0] h_eff;
    logic [DW-1:0]           depth;
    logic                    window_on;
    logic [CW-1:0]           ptr_inc;
    logic                    ptr_last;
    logic                    idx_full;
    logic [POS_W-1:0]        idx_inc;
    logic                    past_lead;
    logic [STEP_W-1:0]       step_eff;
    logic [STEP_W-1:0]       phase_inc;
    logic                    phase_hit;
    logic [COUNT_W-1:0]      ram_rd_data;
    logic [COUNT_W-1:0]      old_count;
    logic [COV_W-1:0]        sum_next;
    logic                    emit;

    // Handshakes: the middle stage moves on whenever the result register is free.
    assign advance  = p1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !p1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Effective half width and window geometry.
    assign h_eff     = (32'(half_width_reg) > 32'(MAX_HALF_WIDTH))
                       ? HALF_WIDTH_W'(MAX_HALF_WIDTH) : half_width_reg;
    assign depth     = {h_eff, 1'b0};
    assign window_on = (h_eff != '0);
    assign ptr_inc   = CW'(ptr_reg) + CW'(1);
    assign ptr_last  = (ptr_inc >= CW'(depth));

    // Position bookkeeping and the step grid.
    assign idx_full  = (index_reg == '1);
    assign idx_inc   = index_reg + POS_W'(1);
    assign past_lead = (idx_inc > POS_W'(h_eff));
    assign step_eff  = (step_reg == '0) ? STEP_W'(1) : step_reg;
    assign phase_inc = phase_reg + STEP_W'(1);
    assign phase_hit = (phase_inc >= step_eff);

    always_comb begin
        p1_next.hit    = !idx_full && past_lead && phase_hit;
        p1_next.pos    = idx_inc - POS_W'(h_eff);
        p1_next.count  = s_tdata[COUNT_W-1:0];
        p1_next.old_ok = wrapped_reg;
    end

    // Delay line: the slot under the pointer is read and overwritten together.
    cswc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_delay_line (
        .clk     (aclk),
        .wr_en   (s_accept && window_on),
        .wr_addr (ptr_reg),
        .wr_data (s_tdata[COUNT_W-1:0]),
        .rd_en   (s_accept && window_on),
        .rd_addr (ptr_reg),
        .rd_data (ram_rd_data)
    );

    // Running sum; a slot not yet written since the restart counts as zero.
    assign old_count = p1_reg.old_ok ? ram_rd_data : '0;
    assign sum_next  = sum_reg + COV_W'(p1_reg.count) - COV_W'(old_count);
    assign emit      = p1_reg.hit && (p1_reg.pos < chrom_size_reg);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= '0;
            step_reg       <= STEP_W'(1);
            chrom_size_reg <= CHROM_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HALF_WIDTH: half_width_reg <= cfg_wdata[HALF_WIDTH_W-1:0];
                REG_STEP:       step_reg       <= cfg_wdata[STEP_W-1:0];
                REG_CHROM_SIZE: chrom_size_reg <= cfg_wdata[CHROM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input side: pointer, base counter and step phase advance per transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
            index_reg   <= '0;
            phase_reg   <= '0;
        end else if (cfg_we && (cfg_reg_t'(cfg_index) == REG_HALF_WIDTH)) begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
            index_reg   <= '0;
            phase_reg   <= '0;
        end else if (s_accept) begin
            if (window_on) begin
                ptr_reg <= ptr_last ? '0 : AW'(ptr_inc);
                if (ptr_last) begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (!idx_full) begin
                index_reg <= idx_inc;
                if (past_lead) begin
                    phase_reg <= phase_hit ? '0 : phase_inc;
                end
            end
        end
    end

    // Middle stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p1_valid_reg <= 1'b1;
        end else if (advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_reg <= p1_next;
        end
    end

    // Running sum, cleared on restart.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (cfg_we && (cfg_reg_t'(cfg_index) == REG_HALF_WIDTH)) begin
            sum_reg <= '0;
        end else if (advance && window_on) begin
            sum_reg <= sum_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= emit;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_pos_reg <= p1_reg.pos;
            m_cov_reg <= window_on ? sum_next : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - POS_W - COV_W)'(0), m_cov_reg, m_pos_reg};

    // With an empty window the running sum never moves off zero.
    `ASSERT_CLK(a_sum_idle_window, aclk, aresetn, (h_eff == '0) |-> (sum_reg == '0), "sum moved with an empty window")
    // The delay-line pointer stays inside the active window.
    `ASSERT_CLK(a_ptr_in_window, aclk, aresetn, window_on |-> (CW'(ptr_reg) < CW'(depth)), "delay pointer beyond window")
    // A result never carries position zero or one at or past the chromosome end.
    `ASSERT_NEVER(a_emit_in_range, aclk, aresetn, m_tvalid_reg && ((m_pos_reg == '0) || (m_pos_reg >= chrom_size_reg)), "result position out of range")

endmodule
